### hdl/rle8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle8_pkg
// Shared types and constants for the 8-bit run-length packet encoder.
// ----------------------------------------------------------------------------
package rle8_pkg;

    localparam int CFG_W   = 16;   // configuration register width
    localparam int PIX_W   = 8;    // pixel and encoded byte width
    localparam int LEN_W   = 8;    // packet length counters, 0..128
    localparam int ADDR_W  = 7;    // literal store address
    localparam int DEPTH   = 128;  // literal store entries
    localparam int BCNT_W  = 3;    // byte_count width

    localparam logic [LEN_W-1:0] MAX_PACKET  = 8'h80;
    localparam logic [LEN_W-1:0] REPEAT_BIAS = 8'h7F;

    // configuration register indexes
    typedef enum logic {
        REG_LINE_WIDTH = 1'b0,
        REG_LINE_COUNT = 1'b1
    } cfg_reg_t;

    // byte issue sequencer phases
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HDR,
        PH_MEM,
        PH_TAIL
    } phase_t;

    // one packet to emit: header, cnt bytes from the literal store, optional tail byte
    typedef struct packed {
        logic              present;
        logic [PIX_W-1:0]  hdr;
        logic [LEN_W-1:0]  cnt;
        logic              tail;
        logic [PIX_W-1:0]  tail_byte;
    } seg_t;

    // one encoded byte handed to the group packer
    typedef struct packed {
        logic              vld;
        logic [PIX_W-1:0]  data;
        logic              last;
        logic              row_end;
        logic              img_end;
    } lane_byte_t;

endpackage

### hdl/rle8_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle8_pack
// Packs the encoded byte stream into groups of up to four bytes and holds
// each finished group in the output register.
// ----------------------------------------------------------------------------
module rle8_pack #(
    parameter int OUT_LANES = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rle8_pkg::lane_byte_t            lane,
    output logic                            advance,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [rle8_pkg::PIX_W-1:0]      byte_0,
    output logic [rle8_pkg::PIX_W-1:0]      byte_1,
    output logic [rle8_pkg::PIX_W-1:0]      byte_2,
    output logic [rle8_pkg::PIX_W-1:0]      byte_3,
    output logic [rle8_pkg::BCNT_W-1:0]     byte_count,
    output logic                            last_of_step,
    output logic                            row_done,
    output logic                            image_done
);
    import rle8_pkg::*;

    localparam int LANES = (OUT_LANES < 1) ? 1 : ((OUT_LANES > 4) ? 4 : OUT_LANES);
    localparam logic [1:0] LAST_LANE = 2'(LANES - 1);

    logic [PIX_W-1:0]  grp_reg [0:2];
    logic [1:0]        grp_cnt_reg;

    logic              out_valid_reg;
    logic [PIX_W-1:0]  b0_reg, b1_reg, b2_reg, b3_reg;
    logic [BCNT_W-1:0] count_reg;
    logic              last_reg, row_reg, img_reg;

    logic              completes;
    logic              take;
    logic [PIX_W-1:0]  b0_next, b1_next, b2_next, b3_next;

    assign completes = lane.vld && (lane.last || (grp_cnt_reg == LAST_LANE));
    // hold the byte when it closes a group and the output register stays full
    assign advance   = !(completes && out_valid_reg && out_stall);
    assign take      = lane.vld && advance;

    always_comb
    begin
        b0_next = (grp_cnt_reg == 2'd0) ? lane.data : grp_reg[0];
        b1_next = (grp_cnt_reg == 2'd1) ? lane.data :
                  ((grp_cnt_reg > 2'd1) ? grp_reg[1] : '0);
        b2_next = (grp_cnt_reg == 2'd2) ? lane.data :
                  ((grp_cnt_reg > 2'd2) ? grp_reg[2] : '0);
        b3_next = (grp_cnt_reg == 2'd3) ? lane.data : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take && completes)
            begin
                grp_cnt_reg   <= '0;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                if (take)
                begin
                    grp_cnt_reg <= grp_cnt_reg + 2'd1;
                end
                if (out_valid_reg && !out_stall)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !completes)
        begin
            grp_reg[grp_cnt_reg] <= lane.data;
        end
        if (take && completes)
        begin
            b0_reg    <= b0_next;
            b1_reg    <= b1_next;
            b2_reg    <= b2_next;
            b3_reg    <= b3_next;
            count_reg <= BCNT_W'(grp_cnt_reg) + 3'd1;
            last_reg  <= lane.last;
            row_reg   <= lane.last && lane.row_end;
            img_reg   <= lane.last && lane.img_end;
        end
    end

    assign out_valid    = out_valid_reg;
    assign byte_0       = b0_reg;
    assign byte_1       = b1_reg;
    assign byte_2       = b2_reg;
    assign byte_3       = b3_reg;
    assign byte_count   = count_reg;
    assign last_of_step = last_reg;
    assign row_done     = row_reg;
    assign image_done   = img_reg;

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (count_reg >= 3'd1) && (count_reg <= BCNT_W'(LANES)))
        else $error("byte_count out of range");

    a_img_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && img_reg) |-> row_reg)
        else $error("image_done without row_done");

    a_row_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && row_reg) |-> last_reg)
        else $error("row_done on a group that is not last of its item");

    a_partial_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (count_reg != BCNT_W'(LANES))) |-> last_reg)
        else $error("short group that is not last of its item");
`endif

endmodule

### hdl/rle_packet_encoder_8bit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_packet_encoder_8bit
// Row-wise run-length packet encoder for 8-bit pixels, literal and repeat
// packets, output packed into groups of up to four bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the in_valid / in_stall channel in row-major order.
//   Encoded packet bytes leave on the out_valid / out_stall channel, up to
//   OUT_LANES bytes per item with byte_count and the last_of_step, row_done
//   and image_done markers on the final group of each pixel.
//   Width and row count are written through cfg_write / cfg_index / cfg_data
//   while the encoder is idle.
// Throughput:
//   A pixel that closes no packet frees the input for the next pixel. A
//   pixel that closes packets holds the input until its bytes have passed
//   the data stage: literal bytes leave the 128-entry literal store at one
//   byte per cycle through its single read port, unless the output stall
//   holds the byte issue; header and tail bytes come from the sequencer. A
//   full literal flush is 129 bytes.
// Reset and stalls:
//   Reset clears the packet state and sets both sizes to 256; the literal
//   store is not cleared. An output stall holds the finished group; new bytes
//   keep collecting until the next group is complete, then the byte issue
//   pauses, and no pixel is taken until all bytes of the last one are out.
// ----------------------------------------------------------------------------
module rle_packet_encoder_8bit #(
    parameter int SIZE_BITS = 16,
    parameter int OUT_LANES = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic                            cfg_index,
    input  logic [rle8_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [rle8_pkg::PIX_W-1:0]      pixel,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [rle8_pkg::PIX_W-1:0]      byte_0,
    output logic [rle8_pkg::PIX_W-1:0]      byte_1,
    output logic [rle8_pkg::PIX_W-1:0]      byte_2,
    output logic [rle8_pkg::PIX_W-1:0]      byte_3,
    output logic [rle8_pkg::BCNT_W-1:0]     byte_count,
    output logic                            last_of_step,
    output logic                            row_done,
    output logic                            image_done
);
    import rle8_pkg::*;

    localparam logic [CFG_W-1:0] SIZE_MASK = CFG_W'((32'd1 << SIZE_BITS) - 32'd1);
    localparam logic [CFG_W-1:0] SIZE_RESET = 16'd256;

    // configuration
    logic [CFG_W-1:0]     line_width_reg, line_count_reg;

    // packet state
    logic                 mode_reg, mode_next;
    logic [LEN_W-1:0]     lit_len_reg, lit_len_next;
    logic [LEN_W-1:0]     rep_len_reg, rep_len_next;
    logic [PIX_W-1:0]     prev_reg, prev_next;
    logic [SIZE_BITS-1:0] col_reg, row_reg;

    // byte issue sequencer
    phase_t               phase_reg, phase_next;
    logic                 seg_sel_reg, seg_sel_next;
    logic [LEN_W-1:0]     idx_reg, idx_next;
    seg_t                 seg1_reg, seg2_reg;
    seg_t                 seg1_c, seg2_c, cur;
    logic [PIX_W-1:0]     pix_reg;
    logic                 wr_pend_reg;
    logic [ADDR_W-1:0]    wr_addr_reg;
    logic                 row_end_reg, img_end_reg;

    // data stage between issue and packer
    logic                 s2_vld_reg, s2_mem_reg, s2_last_reg;
    logic [PIX_W-1:0]     s2_data_reg;

    // literal store
    logic [PIX_W-1:0]     lit_mem [0:DEPTH-1];
    logic [PIX_W-1:0]     mem_q_reg;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [PIX_W-1:0]     mem_wdata;

    logic                 accept;
    logic                 advance;
    logic                 row_end_c, img_end_c, has_bytes;
    logic                 wr_now;
    logic [ADDR_W-1:0]    wr_addr_c;
    logic [CFG_W-1:0]     width_eff, count_eff;
    logic [SIZE_BITS:0]   col_inc, row_inc;
    logic                 issue_vld, issue_mem, issue_last;
    logic [PIX_W-1:0]     issue_data;
    lane_byte_t           lane;

    assign in_stall = !((phase_reg == PH_IDLE) && !s2_vld_reg);
    assign accept   = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // packet decision for the incoming pixel
    // ------------------------------------------------------------------
    always_comb
    begin
        width_eff = (line_width_reg == '0) ? CFG_W'(1) : line_width_reg;
        count_eff = (line_count_reg == '0) ? CFG_W'(1) : line_count_reg;
        col_inc   = {1'b0, col_reg} + (SIZE_BITS+1)'(1);
        row_inc   = {1'b0, row_reg} + (SIZE_BITS+1)'(1);
        row_end_c = ((CFG_W+1)'(col_inc) >= {1'b0, width_eff});
        img_end_c = row_end_c && ((CFG_W+1)'(row_inc) >= {1'b0, count_eff});

        mode_next    = mode_reg;
        lit_len_next = lit_len_reg;
        rep_len_next = rep_len_reg;
        prev_next    = prev_reg;
        seg1_c       = '0;
        wr_now       = 1'b0;
        wr_addr_c    = '0;

        if (col_reg == '0)
        begin
            mode_next    = 1'b0;
            lit_len_next = LEN_W'(1);
            prev_next    = pixel;
            wr_now       = 1'b1;
        end
        else if (!mode_reg)
        begin
            if (lit_len_reg >= MAX_PACKET)
            begin
                // full literal goes out, pixel opens a new one
                seg1_c.present = 1'b1;
                seg1_c.hdr     = MAX_PACKET - 8'd1;
                seg1_c.cnt     = MAX_PACKET;
                lit_len_next   = LEN_W'(1);
                prev_next      = pixel;
                wr_now         = 1'b1;
            end
            else if (pixel != prev_reg)
            begin
                lit_len_next = lit_len_reg + 8'd1;
                prev_next    = pixel;
                wr_now       = 1'b1;
                wr_addr_c    = lit_len_reg[ADDR_W-1:0];
            end
            else
            begin
                // previous pixel leaves the literal and starts a run of two
                if (lit_len_reg > 8'd1)
                begin
                    seg1_c.present = 1'b1;
                    seg1_c.hdr     = lit_len_reg - 8'd2;
                    seg1_c.cnt     = lit_len_reg - 8'd1;
                end
                lit_len_next = '0;
                rep_len_next = LEN_W'(2);
                mode_next    = 1'b1;
                prev_next    = pixel;
            end
        end
        else
        begin
            if ((rep_len_reg >= MAX_PACKET) || (pixel != prev_reg))
            begin
                seg1_c.present   = 1'b1;
                seg1_c.hdr       = rep_len_reg + REPEAT_BIAS;
                seg1_c.tail      = 1'b1;
                seg1_c.tail_byte = prev_reg;
                mode_next        = 1'b0;
                lit_len_next     = LEN_W'(1);
                prev_next        = pixel;
                wr_now           = 1'b1;
            end
            else
            begin
                rep_len_next = rep_len_reg + 8'd1;
            end
        end

        // row end flushes the open packet; a literal's newest pixel is the tail
        seg2_c           = '0;
        seg2_c.present   = row_end_c;
        seg2_c.tail      = 1'b1;
        if (mode_next)
        begin
            seg2_c.hdr       = rep_len_next + REPEAT_BIAS;
            seg2_c.tail_byte = prev_next;
        end
        else
        begin
            seg2_c.hdr       = lit_len_next - 8'd1;
            seg2_c.cnt       = lit_len_next - 8'd1;
            seg2_c.tail_byte = pixel;
        end

        has_bytes = seg1_c.present || row_end_c;
    end

    // ------------------------------------------------------------------
    // byte issue sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            seg_sel_reg <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            seg_sel_reg <= seg_sel_next;
            idx_reg     <= idx_next;
        end
    end

    always_comb
    begin
        cur          = seg_sel_reg ? seg2_reg : seg1_reg;
        phase_next   = phase_reg;
        seg_sel_next = seg_sel_reg;
        idx_next     = idx_reg;
        issue_vld    = 1'b0;
        issue_mem    = 1'b0;
        issue_last   = 1'b0;
        issue_data   = cur.tail_byte;

        case (phase_reg)
            PH_IDLE:
            begin
                if (accept && has_bytes)
                begin
                    phase_next   = PH_HDR;
                    seg_sel_next = !seg1_c.present;
                end
            end
            PH_HDR:
            begin
                issue_vld  = 1'b1;
                issue_data = cur.hdr;
                if (cur.cnt != '0)
                begin
                    phase_next = PH_MEM;
                    idx_next   = '0;
                end
                else if (cur.tail)
                begin
                    phase_next = PH_TAIL;
                end
                else
                begin
                    issue_last = seg_sel_reg || !seg2_reg.present;
                end
            end
            PH_MEM:
            begin
                issue_vld = 1'b1;
                issue_mem = 1'b1;
                if (idx_reg == cur.cnt - 8'd1)
                begin
                    if (cur.tail)
                    begin
                        phase_next = PH_TAIL;
                    end
                    else
                    begin
                        issue_last = seg_sel_reg || !seg2_reg.present;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 8'd1;
                end
            end
            PH_TAIL:
            begin
                issue_vld  = 1'b1;
                issue_last = seg_sel_reg || !seg2_reg.present;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // end of a packet: move to the row-end flush or finish
        if (issue_vld && (phase_next == phase_reg || phase_reg == PH_TAIL ||
            (phase_reg == PH_HDR && cur.cnt == '0 && !cur.tail)) &&
            !(phase_reg == PH_MEM && idx_reg != cur.cnt - 8'd1))
        begin
            if (issue_last)
            begin
                phase_next = PH_IDLE;
            end
            else
            begin
                seg_sel_next = 1'b1;
                phase_next   = PH_HDR;
            end
        end

        if (issue_vld && !advance)
        begin
            phase_next   = phase_reg;
            seg_sel_next = seg_sel_reg;
            idx_next     = idx_reg;
        end
    end

    // ------------------------------------------------------------------
    // state registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= SIZE_RESET;
            line_count_reg <= SIZE_RESET;
            mode_reg       <= 1'b0;
            lit_len_reg    <= '0;
            rep_len_reg    <= '0;
            prev_reg       <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            wr_pend_reg    <= 1'b0;
            s2_vld_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write && (cfg_index == REG_LINE_WIDTH))
            begin
                line_width_reg <= cfg_data & SIZE_MASK;
            end
            if (cfg_write && (cfg_index == REG_LINE_COUNT))
            begin
                line_count_reg <= cfg_data & SIZE_MASK;
            end

            if (accept)
            begin
                mode_reg    <= mode_next;
                lit_len_reg <= lit_len_next;
                rep_len_reg <= rep_len_next;
                prev_reg    <= prev_next;
                wr_pend_reg <= wr_now && has_bytes;
                if (row_end_c)
                begin
                    col_reg <= '0;
                    row_reg <= img_end_c ? '0 : row_inc[SIZE_BITS-1:0];
                end
                else
                begin
                    col_reg <= col_inc[SIZE_BITS-1:0];
                end
            end
            else if (issue_last && advance)
            begin
                wr_pend_reg <= 1'b0;
            end

            if (advance)
            begin
                s2_vld_reg <= issue_vld;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            seg1_reg    <= seg1_c;
            seg2_reg    <= seg2_c;
            pix_reg     <= pixel;
            wr_addr_reg <= wr_addr_c;
            row_end_reg <= row_end_c;
            img_end_reg <= img_end_c;
        end
        if (advance)
        begin
            s2_mem_reg  <= issue_mem;
            s2_data_reg <= issue_data;
            s2_last_reg <= issue_last;
        end
    end

    // ------------------------------------------------------------------
    // literal store: the new pixel is written after all reads of the item
    // ------------------------------------------------------------------
    always_comb
    begin
        if (accept)
        begin
            mem_we    = wr_now && !has_bytes;
            mem_waddr = wr_addr_c;
            mem_wdata = pixel;
        end
        else
        begin
            mem_we    = wr_pend_reg && issue_last && advance;
            mem_waddr = wr_addr_reg;
            mem_wdata = pix_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lit_mem[mem_waddr] <= mem_wdata;
        end
        if (issue_mem && advance)
        begin
            mem_q_reg <= lit_mem[idx_reg[ADDR_W-1:0]];
        end
    end

    assign lane.vld     = s2_vld_reg;
    assign lane.data    = s2_mem_reg ? mem_q_reg : s2_data_reg;
    assign lane.last    = s2_last_reg;
    assign lane.row_end = row_end_reg;
    assign lane.img_end = img_end_reg;

    rle8_pack #(
        .OUT_LANES (OUT_LANES)
    ) u_pack (
        .clk          (clk),
        .rst_n        (rst_n),
        .lane         (lane),
        .advance      (advance),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .byte_0       (byte_0),
        .byte_1       (byte_1),
        .byte_2       (byte_2),
        .byte_3       (byte_3),
        .byte_count   (byte_count),
        .last_of_step (last_of_step),
        .row_done     (row_done),
        .image_done   (image_done)
    );

`ifndef SYNTH
    a_lit_len: assert property (@(posedge clk) disable iff (!rst_n)
        lit_len_reg <= MAX_PACKET)
        else $error("literal length above packet limit");

    a_rep_len: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg |-> (rep_len_reg >= 8'd2) && (rep_len_reg <= MAX_PACKET))
        else $error("repeat length out of range in repeat mode");

    a_mem_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_MEM) |-> (idx_reg < cur.cnt))
        else $error("literal read beyond packet length");

    a_quiet_item: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !has_bytes) |=> !in_stall)
        else $error("item without bytes did not free the input");

    a_wr_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE && !s2_vld_reg) |-> !wr_pend_reg)
        else $error("pending store write left at idle");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 8-bit run-length packet encoder.
// Pixels are driven in row-major order and every byte group is checked
// against an in-bench encoder model or a table entry. A short table covers
// reset geometry, extreme pixels, zero sizes and basic packet shapes. Randomized phases
// follow, with run/literal shaped streams, full 128-pixel packets and a
// mid-row width change, under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module tb;
    import rle8_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int LANES        = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 200;
    localparam int MAX_GAP      = 20;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int USE_MODEL    = -1;   // table row checked by the model only

    typedef struct packed {
        logic [PIX_W-1:0]  b0;
        logic [PIX_W-1:0]  b1;
        logic [PIX_W-1:0]  b2;
        logic [PIX_W-1:0]  b3;
        logic [BCNT_W-1:0] cnt;
        logic              last;
        logic              rowd;
        logic              imgd;
    } grp_t;

    typedef struct {
        bit   typed;
        int   n;
        grp_t g;
    } item_tag_t;

    typedef enum {
        DR_PIXEL,
        DR_GEOMETRY
    } dir_kind_t;

    typedef struct {
        dir_kind_t   kind;
        logic [15:0] a;       // pixel, or line width
        logic [15:0] b;       // line count
        int          typed;
        grp_t        g;
    } dir_row_t;

    typedef enum {
        SEG_RUN,
        SEG_LITERAL,
        SEG_NOISE_NARROW,
        SEG_NOISE_WIDE
    } seg_kind_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_write;
    logic              cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic [PIX_W-1:0]  pixel;
    logic              out_valid;
    logic              out_stall;
    logic [PIX_W-1:0]  byte_0;
    logic [PIX_W-1:0]  byte_1;
    logic [PIX_W-1:0]  byte_2;
    logic [PIX_W-1:0]  byte_3;
    logic [BCNT_W-1:0] byte_count;
    logic              last_of_step;
    logic              row_done;
    logic              image_done;

    // encoder model state
    logic [CFG_W-1:0]  geo_width;
    logic [CFG_W-1:0]  geo_count;
    bit                in_repeat;
    int                lit_len;
    int                run_len;
    logic [PIX_W-1:0]  last_pix;
    logic [PIX_W-1:0]  lit_mem [DEPTH];
    int                col_idx;
    int                row_idx;
    logic [PIX_W-1:0]  packet_bytes [$];
    grp_t              step_groups [$];

    grp_t              expected_groups [$];
    item_tag_t         item_tags [$];
    dir_row_t          dir_tab [22];

    int idle_pct;
    int stall_pct;
    bit hold_req;
    int hold_left;
    int cycle_cnt;
    int err_cnt;
    int pixels_done;
    int groups_done;
    int rows_done;
    int full_literals;
    int full_runs;
    int settings_done;

    rle_packet_encoder_8bit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel        (pixel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .byte_0       (byte_0),
        .byte_1       (byte_1),
        .byte_2       (byte_2),
        .byte_3       (byte_3),
        .byte_count   (byte_count),
        .last_of_step (last_of_step),
        .row_done     (row_done),
        .image_done   (image_done)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // encoder model
    // ------------------------------------------------------------------------
    function automatic void flush_literal(input int n);
        int i;
        if (n == 0)
            return;
        packet_bytes.push_back(PIX_W'(n - 1));
        for (i = 0; i < n; i++)
            packet_bytes.push_back(lit_mem[i]);
        if (n == int'(MAX_PACKET))
            full_literals++;
    endfunction

    function automatic void flush_run();
        packet_bytes.push_back(PIX_W'(run_len) + REPEAT_BIAS);
        packet_bytes.push_back(last_pix);
        if (run_len == int'(MAX_PACKET))
            full_runs++;
    endfunction

    function automatic void start_literal(input logic [PIX_W-1:0] p);
        in_repeat  = 1'b0;
        lit_mem[0] = p;
        lit_len    = 1;
        last_pix   = p;
    endfunction

    function automatic void encode_pixel(input logic [PIX_W-1:0] p);
        int   w_eff;
        int   c_eff;
        int   k;
        int   nb;
        bit   row_end;
        bit   img_end;
        grp_t g;
        packet_bytes.delete();
        step_groups.delete();
        row_end = 1'b0;
        img_end = 1'b0;
        w_eff = (geo_width == '0) ? 1 : int'(geo_width);
        c_eff = (geo_count == '0) ? 1 : int'(geo_count);

        if (col_idx == 0) begin
            start_literal(p);
        end else if (!in_repeat) begin
            if (lit_len >= int'(MAX_PACKET)) begin
                flush_literal(lit_len);
                start_literal(p);
            end else if (p != last_pix) begin
                lit_mem[lit_len] = p;
                lit_len++;
                last_pix = p;
            end else begin
                // first of the equal pair leaves the literal
                if (lit_len > 1)
                    flush_literal(lit_len - 1);
                lit_len   = 0;
                run_len   = 2;
                in_repeat = 1'b1;
                last_pix  = p;
            end
        end else begin
            if (run_len >= int'(MAX_PACKET) || p != last_pix) begin
                flush_run();
                start_literal(p);
            end else begin
                run_len++;
            end
        end

        if (col_idx + 1 >= w_eff) begin
            if (in_repeat)
                flush_run();
            else
                flush_literal(lit_len);
            row_end = 1'b1;
            col_idx = 0;
            if (row_idx + 1 >= c_eff) begin
                img_end = 1'b1;
                row_idx = 0;
            end else begin
                row_idx++;
            end
        end else begin
            col_idx++;
        end

        for (k = 0; k < packet_bytes.size(); k += LANES) begin
            nb = packet_bytes.size() - k;
            if (nb > LANES)
                nb = LANES;
            g = '0;
            g.b0 = packet_bytes[k];
            if (nb > 1)
                g.b1 = packet_bytes[k + 1];
            if (nb > 2)
                g.b2 = packet_bytes[k + 2];
            if (nb > 3)
                g.b3 = packet_bytes[k + 3];
            g.cnt  = BCNT_W'(nb);
            g.last = (k + LANES >= packet_bytes.size());
            g.rowd = g.last && row_end;
            g.imgd = g.last && img_end;
            step_groups.push_back(g);
        end
    endfunction

    function automatic string fmt_group(input grp_t g);
        return $sformatf("bytes %h %h %h %h count %0d last %b row %b image %b",
                         g.b0, g.b1, g.b2, g.b3, g.cnt, g.last, g.rowd, g.imgd);
    endfunction

    // ------------------------------------------------------------------------
    // model update and output check, one process so edge order is fixed
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        grp_t      got;
        item_tag_t tag;
        if (rst_n) begin
            if (cfg_write) begin
                if (cfg_reg_t'(cfg_index) == REG_LINE_WIDTH)
                    geo_width = cfg_data;
                else
                    geo_count = cfg_data;
            end
            if (in_valid && !in_stall) begin
                tag = item_tags.pop_front();
                encode_pixel(pixel);
                pixels_done++;
                if (step_groups.size() != 0 && step_groups[$].rowd)
                    rows_done++;
                if (tag.typed) begin
                    if (tag.n == 1)
                        expected_groups.push_back(tag.g);
                end else begin
                    foreach (step_groups[i])
                        expected_groups.push_back(step_groups[i]);
                end
            end
            if (out_valid && !out_stall) begin
                got = {byte_0, byte_1, byte_2, byte_3, byte_count,
                       last_of_step, row_done, image_done};
                groups_done++;
                if (expected_groups.size() == 0) begin
                    $display("%0t: unexpected group, actual %s", $time, fmt_group(got));
                    err_cnt++;
                end else if (got !== expected_groups[0]) begin
                    $display("%0t: mismatch, expected %s, actual %s", $time,
                             fmt_group(expected_groups[0]), fmt_group(got));
                    err_cnt++;
                    void'(expected_groups.pop_front());
                end else begin
                    void'(expected_groups.pop_front());
                end
            end
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d groups still expected", $time,
                     expected_groups.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic send_pixel(input logic [PIX_W-1:0] v, input item_tag_t tag);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_tags.push_back(tag);
        in_valid <= 1'b1;
        pixel    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_groups.size() != 0)
            @(posedge clk);
        // a pixel with no output may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] c);
        cfg_write <= 1'b1;
        cfg_index <= REG_LINE_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= REG_LINE_COUNT;
        cfg_data  <= c;
        @(posedge clk);
        cfg_write <= 1'b0;
        settings_done++;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] c,
                             input int n, input int idle_p, input int stall_p,
                             input bit long_rows, input bit hold);
        int               w_eff;
        int               col_t;
        int               rows_t;
        int               seg_left;
        int               r;
        int               i;
        seg_kind_t        seg;
        logic [PIX_W-1:0] v;
        logic [PIX_W-1:0] prev_v;
        logic [PIX_W-1:0] run_v;
        item_tag_t        tag;
        drain();
        set_geometry(w, c);
        idle_pct  = idle_p;
        stall_pct = stall_p;
        if (hold)
            hold_req = 1'b1;
        w_eff    = (w == '0) ? 1 : int'(w);
        col_t    = 0;
        rows_t   = 0;
        seg_left = 0;
        seg      = SEG_NOISE_WIDE;
        prev_v   = '0;
        run_v    = '0;
        tag      = '{1'b0, 0, '0};
        for (i = 0; i < n; i++) begin
            if (seg_left == 0) begin
                if (long_rows && col_t == 0) begin
                    // rows alternate a full literal and a full repeat, then overflow
                    seg      = rows_t[0] ? SEG_RUN : SEG_LITERAL;
                    seg_left = $urandom_range(129, 133);
                end else begin
                    r = $urandom_range(0, 9);
                    if (r < 4) begin
                        seg      = SEG_RUN;
                        seg_left = $urandom_range(2, 8);
                    end else if (r < 7) begin
                        seg      = SEG_LITERAL;
                        seg_left = $urandom_range(1, 8);
                    end else if (r < 9) begin
                        seg      = SEG_NOISE_NARROW;
                        seg_left = $urandom_range(1, 6);
                    end else begin
                        seg      = SEG_NOISE_WIDE;
                        seg_left = $urandom_range(1, 6);
                    end
                end
                run_v = PIX_W'($urandom_range(0, 255));
            end
            case (seg)
                SEG_RUN:          v = run_v;
                SEG_LITERAL:
                begin
                    v = PIX_W'($urandom_range(0, 255));
                    if (v == prev_v)
                        v = ~v;
                end
                SEG_NOISE_NARROW: v = PIX_W'($urandom_range(0, 2));
                default:          v = PIX_W'($urandom_range(0, 255));
            endcase
            seg_left--;
            send_pixel(v, tag);
            prev_v = v;
            if (col_t + 1 >= w_eff) begin
                col_t = 0;
                rows_t++;
            end else begin
                col_t++;
            end
        end
    endtask

    initial begin
        item_tag_t tag;
        int        n_directed;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_LINE_WIDTH;
        cfg_data  = '0;
        in_valid  = 1'b0;
        pixel     = '0;
        out_stall = 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 1'b0;
        hold_left = 0;
        cycle_cnt = 0;
        err_cnt   = 0;
        pixels_done   = 0;
        groups_done   = 0;
        rows_done     = 0;
        full_literals = 0;
        full_runs     = 0;
        settings_done = 0;
        geo_width = 16'd256;
        geo_count = 16'd256;
        in_repeat = 1'b0;
        lit_len   = 0;
        run_len   = 0;
        last_pix  = '0;
        col_idx   = 0;
        row_idx   = 0;

        dir_tab = '{
            // reset geometry: no row end yet
            '{DR_PIXEL,    16'h11, 16'd0, 0, '0},
            '{DR_PIXEL,    16'h22, 16'd0, 0, '0},
            // width drops below the column: next pixel closes row and image
            '{DR_GEOMETRY, 16'd1,  16'd1, 0, '0},
            '{DR_PIXEL,    16'h33, 16'd0, 1,
              '{8'h02, 8'h11, 8'h22, 8'h33, 3'd4, 1'b1, 1'b1, 1'b1}},
            '{DR_PIXEL,    16'h00, 16'd0, 1,
              '{8'h00, 8'h00, 8'h00, 8'h00, 3'd2, 1'b1, 1'b1, 1'b1}},
            '{DR_PIXEL,    16'hFF, 16'd0, 1,
              '{8'h00, 8'hFF, 8'h00, 8'h00, 3'd2, 1'b1, 1'b1, 1'b1}},
            // zero sizes act as one
            '{DR_GEOMETRY, 16'd0,  16'd0, 0, '0},
            '{DR_PIXEL,    16'hA5, 16'd0, 1,
              '{8'h00, 8'hA5, 8'h00, 8'h00, 3'd2, 1'b1, 1'b1, 1'b1}},
            '{DR_PIXEL,    16'h5A, 16'd0, 1,
              '{8'h00, 8'h5A, 8'h00, 8'h00, 3'd2, 1'b1, 1'b1, 1'b1}},
            '{DR_GEOMETRY, 16'd6,  16'd2, 0, '0},
            // repeat at row start, literal cut by an equal pair, repeat at row end
            '{DR_PIXEL,    16'h10, 16'd0, USE_MODEL, '0},
            '{DR_PIXEL,    16'h10, 16'd0, USE_MODEL, '0},
            '{DR_PIXEL,    16'h10, 16'd0, USE_MODEL, '0},
            '{DR_PIXEL,    16'h20, 16'd0, USE_MODEL, '0},
            '{DR_PIXEL,    16'h30, 16'd0, USE_MODEL, '0},
            '{DR_PIXEL,    16'h30, 16'd0, USE_MODEL, '0},
            // literal, pair inside, literal at row end, last row of image
            '{DR_PIXEL,    16'h01, 16'd0, USE_MODEL, '0},
            '{DR_PIXEL,    16'h02, 16'd0, USE_MODEL, '0},
            '{DR_PIXEL,    16'h03, 16'd0, USE_MODEL, '0},
            '{DR_PIXEL,    16'h03, 16'd0, USE_MODEL, '0},
            '{DR_PIXEL,    16'h04, 16'd0, USE_MODEL, '0},
            '{DR_PIXEL,    16'h05, 16'd0, USE_MODEL, '0}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        n_directed = 0;
        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == DR_GEOMETRY) begin
                drain();
                set_geometry(dir_tab[i].a, dir_tab[i].b);
            end else begin
                tag.typed = (dir_tab[i].typed != USE_MODEL);
                tag.n     = dir_tab[i].typed;
                tag.g     = dir_tab[i].g;
                send_pixel(dir_tab[i].a[PIX_W-1:0], tag);
                n_directed++;
            end
        end

        //        width     count     items idle stall long  hold
        run_phase(16'd7,     16'd3,     20,   0,   0, 1'b0, 1'b0);
        run_phase(16'd135,   16'd2,    270,  62,   0, 1'b1, 1'b0);
        run_phase(16'd3,     16'd65535, 25,   0,  62, 1'b0, 1'b1);
        run_phase(16'd16,    16'd1,     20,  21,  21, 1'b0, 1'b0);
        // wide row left open, then cut short by the next width
        run_phase(16'd65535, 16'd65535, 10,   0,   0, 1'b0, 1'b0);
        run_phase(16'd1,     16'd1,      6,  62,  62, 1'b0, 1'b0);
        drain();

        $display("Encoded %0d pixels (%0d from table) in %0d rows over %0d size settings",
                 pixels_done, n_directed, rows_done, settings_done);
        $display("Checked %0d byte groups; %0d full literals, %0d full repeats, %0d errors",
                 groups_done, full_literals, full_runs, err_cnt);
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
hdl/rle8_pkg.sv
hdl/rle8_pack.sv
hdl/rle_packet_encoder_8bit.sv
tb/tb.sv
